@@ design/pb_pkg.sv @@
// ----------------------------------------------------------------------------
// pb_pkg: shared types for the palette builder
// Controller states and the token that walks the row of palette cells.
// ----------------------------------------------------------------------------
package pb_pkg;

  // width of one packed rgb colour
  localparam int unsigned ColourW = 24;

  // op codes of an input transaction
  localparam logic OpClear    = 1'b0;
  localparam logic OpClassify = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_DONE
  } state_t;

  // lookup token handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic               hit;
    logic               added;
    logic [ColourW-1:0] colour;
  } token_t;

endpackage

@@ design/pb_in_if.sv @@
// ----------------------------------------------------------------------------
// pb_in_if: pixel input channel
// Valid/ready channel carrying one clear or classify transaction.
// ----------------------------------------------------------------------------
interface pb_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output op, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input op, input red, input green, input blue,
                  output ready);
endinterface

@@ design/pb_out_if.sv @@
// ----------------------------------------------------------------------------
// pb_out_if: classification result channel
// Valid/ready channel carrying one result transaction per input transaction.
// ----------------------------------------------------------------------------
interface pb_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] colour_index;
  logic       index_valid;
  logic       newly_added;
  logic       overflowed;
  logic [7:0] entries_used;

  modport source (output valid, output colour_index, output index_valid,
                  output newly_added, output overflowed, output entries_used,
                  input ready);
  modport sink   (input valid, input colour_index, input index_valid,
                  input newly_added, input overflowed, input entries_used,
                  output ready);
endinterface

@@ design/pb_cell.sv @@
// ----------------------------------------------------------------------------
// pb_cell: one palette entry
// Holds a single colour, compares the passing token against it and claims
// the token on a match or when it is the first free entry.
// ----------------------------------------------------------------------------
module pb_cell #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned K     = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [$clog2(DEPTH+1)-1:0] fill_count,
  input  pb_pkg::token_t             tok_in,
  input  logic [$clog2(DEPTH)-1:0]   idx_in,
  output pb_pkg::token_t             tok_out,
  output logic [$clog2(DEPTH)-1:0]   idx_out
);

  localparam int unsigned FillW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW  = $clog2(DEPTH);

  logic [pb_pkg::ColourW-1:0] entry;
  logic                       filled;
  logic                       at_end;
  logic                       open;
  logic                       match;
  logic                       append;

  // entry position relative to the fill level
  assign filled = FillW'(K) < fill_count;
  assign at_end = FillW'(K) == fill_count;
  assign open   = tok_in.valid && !tok_in.hit;
  assign match  = open && filled && (entry == tok_in.colour);
  assign append = open && at_end;

  // store a new colour in the first free entry
  always_ff @(posedge clk) begin
    if (append) begin
      entry <= tok_in.colour;
    end
  end

  // hand the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.hit    <= tok_in.hit | match | append;
    tok_out.added  <= tok_in.added | append;
    tok_out.colour <= tok_in.colour;
    idx_out        <= (match || append) ? IdxW'(K) : idx_in;
  end

endmodule

@@ design/pb_ctrl.sv @@
// ----------------------------------------------------------------------------
// pb_ctrl: transaction control for the palette builder
// Launches tokens into the cell row, keeps the fill count and overflow flag,
// and holds the result until the sink takes it.
// ----------------------------------------------------------------------------
module pb_ctrl #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                       clk,
  input  logic                       rst,
  pb_in_if.sink                      pix,
  pb_out_if.source                   res,
  output pb_pkg::token_t             head_tok,
  output logic [$clog2(DEPTH)-1:0]   head_idx,
  input  pb_pkg::token_t             tail_tok,
  input  logic [$clog2(DEPTH)-1:0]   tail_idx,
  output logic [$clog2(DEPTH+1)-1:0] fill_count
);

  localparam int unsigned FillW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW  = $clog2(DEPTH);

  pb_pkg::state_t state;
  pb_pkg::state_t state_next;

  logic            overflow_flag;
  logic [IdxW-1:0] res_index;
  logic            res_valid;
  logic            res_added;
  logic            accept;

  assign accept = pix.valid && pix.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pb_pkg::ST_IDLE: begin
        if (pix.valid) begin
          state_next = (pix.op == pb_pkg::OpClassify) ? pb_pkg::ST_BUSY : pb_pkg::ST_DONE;
        end
      end
      pb_pkg::ST_BUSY: begin
        if (tail_tok.valid) begin
          state_next = pb_pkg::ST_DONE;
        end
      end
      pb_pkg::ST_DONE: begin
        if (res.ready) begin
          state_next = pb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // handshake outputs, no transaction taken while in reset
  always_comb begin
    pix.ready = 1'b0;
    res.valid = 1'b0;
    case (state)
      pb_pkg::ST_IDLE: pix.ready = !rst;
      pb_pkg::ST_DONE: res.valid = 1'b1;
      default: begin
        pix.ready = 1'b0;
        res.valid = 1'b0;
      end
    endcase
  end

  // token launched into the first cell
  always_comb begin
    head_tok.valid  = accept && (pix.op == pb_pkg::OpClassify);
    head_tok.hit    = 1'b0;
    head_tok.added  = 1'b0;
    head_tok.colour = {pix.red, pix.green, pix.blue};
    head_idx        = '0;
  end

  // fill count and sticky overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      overflow_flag <= 1'b0;
    end else if (accept && (pix.op == pb_pkg::OpClear)) begin
      fill_count    <= '0;
      overflow_flag <= 1'b0;
    end else if (tail_tok.valid) begin
      if (tail_tok.added) begin
        fill_count <= fill_count + FillW'(1);
      end
      if (!tail_tok.hit) begin
        overflow_flag <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept && (pix.op == pb_pkg::OpClear)) begin
      res_index <= '0;
      res_valid <= 1'b0;
      res_added <= 1'b0;
    end else if (tail_tok.valid) begin
      res_index <= tail_tok.hit ? tail_idx : '0;
      res_valid <= tail_tok.hit;
      res_added <= tail_tok.added;
    end
  end

  assign res.colour_index = 7'(res_index);
  assign res.index_valid  = res_valid;
  assign res.newly_added  = res_added;
  assign res.overflowed   = overflow_flag;
  assign res.entries_used = 8'(fill_count);

endmodule

@@ design/palette_builder.sv @@
// ----------------------------------------------------------------------------
// palette_builder: distinct colour palette from a pixel stream
// Row of palette cells walked by one lookup token per pixel.
// ----------------------------------------------------------------------------
// Each classify transaction sends a token down a row of PALETTE_DEPTH cells,
// one cell per cycle; the first filled cell holding the same colour claims it,
// or else the first free cell stores the colour. One transaction is in flight
// at a time, and a result waits in its output register until the sink takes
// it. Entries past the fill count are never compared, so a clear leaves the
// stored entries as they are and resets only the fill count, the overflow
// flag and the result register.
module palette_builder #(
  parameter int unsigned PALETTE_DEPTH = 128
) (
  input  logic     clk,
  input  logic     rst,
  pb_in_if.sink    pix,
  pb_out_if.source res
);

  localparam int unsigned FillW = $clog2(PALETTE_DEPTH + 1);
  localparam int unsigned IdxW  = $clog2(PALETTE_DEPTH);

  pb_pkg::token_t  tok [PALETTE_DEPTH+1];
  logic [IdxW-1:0] idx [PALETTE_DEPTH+1];
  logic [FillW-1:0] fill_count;

  // control and result register
  pb_ctrl #(
    .DEPTH (PALETTE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .pix        (pix),
    .res        (res),
    .head_tok   (tok[0]),
    .head_idx   (idx[0]),
    .tail_tok   (tok[PALETTE_DEPTH]),
    .tail_idx   (idx[PALETTE_DEPTH]),
    .fill_count (fill_count)
  );

  // row of palette cells
  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    pb_cell #(
      .DEPTH (PALETTE_DEPTH),
      .K     (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .fill_count (fill_count),
      .tok_in     (tok[k]),
      .idx_in     (idx[k]),
      .tok_out    (tok[k+1]),
      .idx_out    (idx[k+1])
    );
  end

endmodule
